// ----- sv/thrusted_body_euler_step_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the thrusted body Euler step block
// Implication checks with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef THRUSTED_BODY_EULER_STEP_ASSERT_SVH
`define THRUSTED_BODY_EULER_STEP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TBES_ASSERT_NOW(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tbes check failed");

// Next-cycle implication, disabled during reset.
`define TBES_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tbes check failed");

// Next-cycle implication, active during reset as well.
`define TBES_ASSERT_NEXT_ANY(name, ck, ante, cons) \
  name: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("tbes check failed");

`endif

// ----- sv/tbes_pkg.sv -----
// ----------------------------------------------------------------------------
// tbes_pkg
// Types, constants and helper functions for the thrusted body Euler step.
// ----------------------------------------------------------------------------
`default_nettype none

package tbes_pkg;

  typedef struct packed {
    logic [15:0]        time_step;
    logic               firing;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } cmd_t;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic [23:0]        propellant_left;
    logic               thrust_applied;
  } res_t;

  typedef enum logic [1:0] {
    REG_DRY_MASS,
    REG_START_PROP,
    REG_MAX_THRUST,
    REG_BURN_RATE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUMX,
    ST_NUMY,
    ST_BURN,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_SCLO,
    ST_SCHI,
    ST_SCACC,
    ST_OUT
  } st_t;

  localparam logic [23:0] DRY_MASS_RST   = 24'd38400;
  localparam logic [23:0] START_PROP_RST = 24'd12800;
  localparam logic [15:0] MAX_THRUST_RST = 16'd500;
  localparam logic [23:0] BURN_RATE_RST  = 24'd26;

  localparam int DIV_W     = 41;
  localparam int DIV_CNT_W = 6;
  localparam int MASS_W    = 25;
  localparam int NUM_W     = 31;

  localparam logic signed [42:0] S40_MAX = 43'sd549755813887;
  localparam logic signed [42:0] S40_MIN = -43'sd549755813888;

  function automatic logic [40:0] mag40(input logic signed [39:0] v);
    logic [39:0] m;
    m = v[39] ? 40'(-v) : 40'(v);
    return {1'b0, m};
  endfunction

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = {v[15], v};
    return v[15] ? 17'(-w) : 17'(w);
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
    logic signed [39:0] r;
    if (v > S40_MAX) begin
      r = S40_MAX[39:0];
    end else if (v < S40_MIN) begin
      r = S40_MIN[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tbes_mul.sv -----
// ----------------------------------------------------------------------------
// tbes_mul
// Shared 24x16 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tbes_mul (
  input  wire logic        clk,
  input  wire logic [23:0] a,
  input  wire logic [15:0] b,
  output logic      [39:0] p
);

  always_ff @(posedge clk) begin
    p <= 40'(a) * 40'(b);
  end

endmodule

`default_nettype wire

// ----- sv/tbes_div.sv -----
// ----------------------------------------------------------------------------
// tbes_div
// Restoring divider, one quotient bit per cycle, two lanes sharing a divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tbes_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [tbes_pkg::DIV_W-1:0]        dividend_x,
  input  wire logic [tbes_pkg::DIV_W-1:0]        dividend_y,
  input  wire logic [tbes_pkg::MASS_W-1:0]       divisor,
  output logic                                   done,
  output logic      [tbes_pkg::DIV_W-1:0]        quot_x,
  output logic      [tbes_pkg::DIV_W-1:0]        quot_y
);

  localparam int DW = tbes_pkg::DIV_W;
  localparam int MW = tbes_pkg::MASS_W;

  logic                            busy;
  logic [tbes_pkg::DIV_CNT_W-1:0]  cnt;
  logic [DW-1:0]                   dvd_x;
  logic [DW-1:0]                   dvd_y;
  logic [MW-1:0]                   rem_x;
  logic [MW-1:0]                   rem_y;
  logic [MW:0]                     trial_x;
  logic [MW:0]                     trial_y;
  logic                            ge_x;
  logic                            ge_y;
  logic [MW-1:0]                   rem_x_next;
  logic [MW-1:0]                   rem_y_next;

  always_comb begin
    trial_x = {rem_x, dvd_x[DW-1]};
    trial_y = {rem_y, dvd_y[DW-1]};
    ge_x    = trial_x >= {1'b0, divisor};
    ge_y    = trial_y >= {1'b0, divisor};
    rem_x_next = ge_x ? MW'(trial_x - {1'b0, divisor}) : trial_x[MW-1:0];
    rem_y_next = ge_y ? MW'(trial_y - {1'b0, divisor}) : trial_y[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tbes_pkg::DIV_CNT_W'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_x <= dividend_x;
      dvd_y <= dividend_y;
      rem_x <= '0;
      rem_y <= '0;
    end else if (busy) begin
      dvd_x  <= {dvd_x[DW-2:0], 1'b0};
      dvd_y  <= {dvd_y[DW-2:0], 1'b0};
      rem_x  <= rem_x_next;
      rem_y  <= rem_y_next;
      quot_x <= {quot_x[DW-2:0], ge_x};
      quot_y <= {quot_y[DW-2:0], ge_y};
    end
  end

endmodule

`default_nettype wire

// ----- sv/thrusted_body_euler_step.sv -----
// ----------------------------------------------------------------------------
// thrusted_body_euler_step
// One semi-implicit Euler step of a thrusted 2-D body per command.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// cmd      in   cmd_valid / cmd_ready  tbes_pkg::cmd_t
// res      out  res_valid / res_ready  tbes_pkg::res_t
// cfg      in   APB r/w, pready = 1    four registers at 4*index
//
// A thrusting tick runs the 41-step restoring divider plus eleven passes
// through the shared 24x16 multiplier; a coasting tick skips the divide and
// the burn. The result turns valid in the same cycle that cmd_ready rises.
// Reset loads register defaults, zero motion, propellant 12800.
// The result register holds a transaction until taken; the next command is
// accepted meanwhile, and a finished tick waits until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module thrusted_body_euler_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire tbes_pkg::cmd_t  cmd,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output tbes_pkg::res_t       res,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tbes_pkg::st_t state;
  tbes_pkg::st_t state_next;

  logic [23:0]        dry_mass;
  logic [23:0]        start_propellant;
  logic [15:0]        max_thrust;
  logic [23:0]        burn_rate;

  logic signed [39:0] position_x;
  logic signed [39:0] position_y;
  logic signed [39:0] velocity_x;
  logic signed [39:0] velocity_y;
  logic [23:0]        propellant;

  logic [15:0]        dt;
  logic               dx_neg;
  logic               dy_neg;
  logic [16:0]        dx_mag;
  logic [16:0]        dy_mag;
  logic               applied;
  logic [24:0]        mass;
  logic [30:0]        num_x;
  logic [30:0]        num_y;
  logic [40:0]        ax_mag;
  logic [40:0]        ay_mag;
  logic [1:0]         sel;
  logic [39:0]        acc_lo;

  logic [23:0]        mul_a;
  logic [15:0]        mul_b;
  logic [39:0]        mul_p;
  logic               div_start;
  logic               div_done;
  logic [40:0]        quot_x;
  logic [40:0]        quot_y;

  logic               cmd_fire;
  logic               cfg_we;
  logic [40:0]        op_mag;
  logic               op_neg;
  logic signed [39:0] op_tgt;
  logic [56:0]        scaled;
  logic signed [42:0] dv;
  logic signed [42:0] tgt_sum;
  logic signed [39:0] tgt_new;
  logic [23:0]        burned;
  logic               res_free;

  tbes_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tbes_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_x ({num_x, 10'b0}),
    .dividend_y ({num_y, 10'b0}),
    .divisor    (mass),
    .done       (div_done),
    .quot_x     (quot_x),
    .quot_y     (quot_y)
  );

  assign pready    = 1'b1;
  assign cfg_we    = psel & penable & pwrite;
  assign cmd_ready = (state == tbes_pkg::ST_IDLE);
  assign cmd_fire  = cmd_valid & cmd_ready;
  assign res_free  = !res_valid || res_ready;

  always_comb begin
    unique case (tbes_pkg::reg_idx_t'(paddr[3:2]))
      tbes_pkg::REG_DRY_MASS:   prdata = {8'b0, dry_mass};
      tbes_pkg::REG_START_PROP: prdata = {8'b0, start_propellant};
      tbes_pkg::REG_MAX_THRUST: prdata = {16'b0, max_thrust};
      tbes_pkg::REG_BURN_RATE:  prdata = {8'b0, burn_rate};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    case (sel)
      2'd0:    begin op_mag = ax_mag; op_neg = dx_neg; op_tgt = velocity_x; end
      2'd1:    begin op_mag = ay_mag; op_neg = dy_neg; op_tgt = velocity_y; end
      2'd2:    begin
        op_mag = tbes_pkg::mag40(velocity_x); op_neg = velocity_x[39]; op_tgt = position_x;
      end
      default: begin
        op_mag = tbes_pkg::mag40(velocity_y); op_neg = velocity_y[39]; op_tgt = position_y;
      end
    endcase
    scaled  = 57'(acc_lo) + {mul_p[32:0], 24'b0};
    dv      = op_neg ? -$signed({2'b0, scaled[56:16]}) : $signed({2'b0, scaled[56:16]});
    tgt_sum = {{3{op_tgt[39]}}, op_tgt} + dv;
    tgt_new = tbes_pkg::sat40(tgt_sum);
    burned  = mul_p[39:16];
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = dt;
    div_start  = 1'b0;
    unique case (state)
      tbes_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          state_next = (cmd.firing && propellant != '0) ? tbes_pkg::ST_NUMX
                                                        : tbes_pkg::ST_SCLO;
        end
      end
      tbes_pkg::ST_NUMX: begin
        mul_a      = {7'b0, dx_mag};
        mul_b      = max_thrust;
        state_next = tbes_pkg::ST_NUMY;
      end
      tbes_pkg::ST_NUMY: begin
        mul_a      = {7'b0, dy_mag};
        mul_b      = max_thrust;
        state_next = tbes_pkg::ST_BURN;
      end
      tbes_pkg::ST_BURN: begin
        mul_a      = burn_rate;
        state_next = tbes_pkg::ST_DIVGO;
      end
      tbes_pkg::ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = tbes_pkg::ST_DIVWAIT;
      end
      tbes_pkg::ST_DIVWAIT: begin
        if (div_done) begin
          state_next = tbes_pkg::ST_SCLO;
        end
      end
      tbes_pkg::ST_SCLO: begin
        mul_a      = op_mag[23:0];
        state_next = tbes_pkg::ST_SCHI;
      end
      tbes_pkg::ST_SCHI: begin
        mul_a      = {7'b0, op_mag[40:24]};
        state_next = tbes_pkg::ST_SCACC;
      end
      tbes_pkg::ST_SCACC: begin
        state_next = (sel == 2'd3) ? tbes_pkg::ST_OUT : tbes_pkg::ST_SCLO;
      end
      tbes_pkg::ST_OUT: begin
        if (res_free) begin
          state_next = tbes_pkg::ST_IDLE;
        end
      end
      default: state_next = tbes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_mass         <= tbes_pkg::DRY_MASS_RST;
      start_propellant <= tbes_pkg::START_PROP_RST;
      max_thrust       <= tbes_pkg::MAX_THRUST_RST;
      burn_rate        <= tbes_pkg::BURN_RATE_RST;
      propellant       <= tbes_pkg::START_PROP_RST;
      position_x       <= '0;
      position_y       <= '0;
      velocity_x       <= '0;
      velocity_y       <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (tbes_pkg::reg_idx_t'(paddr[3:2]))
          tbes_pkg::REG_DRY_MASS:   dry_mass <= pwdata[23:0];
          tbes_pkg::REG_START_PROP: begin
            start_propellant <= pwdata[23:0];
            propellant       <= pwdata[23:0];
          end
          tbes_pkg::REG_MAX_THRUST: max_thrust <= pwdata[15:0];
          tbes_pkg::REG_BURN_RATE:  burn_rate <= pwdata[23:0];
          default: ;
        endcase
      end
      if (state == tbes_pkg::ST_DIVGO) begin
        propellant <= (propellant > burned) ? propellant - burned : '0;
      end
      if (state == tbes_pkg::ST_SCACC) begin
        case (sel)
          2'd0:    velocity_x <= tgt_new;
          2'd1:    velocity_y <= tgt_new;
          2'd2:    position_x <= tgt_new;
          default: position_y <= tgt_new;
        endcase
      end
      if (state == tbes_pkg::ST_OUT && res_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      dt      <= cmd.time_step;
      dx_neg  <= cmd.dir_x[15];
      dy_neg  <= cmd.dir_y[15];
      dx_mag  <= tbes_pkg::mag16(cmd.dir_x);
      dy_mag  <= tbes_pkg::mag16(cmd.dir_y);
      applied <= cmd.firing && propellant != '0;
      mass    <= 25'(dry_mass) + 25'(propellant);
      ax_mag  <= '0;
      ay_mag  <= '0;
      sel     <= '0;
    end
    if (state == tbes_pkg::ST_NUMY) begin
      num_x <= mul_p[30:0];
    end
    if (state == tbes_pkg::ST_BURN) begin
      num_y <= mul_p[30:0];
    end
    if (state == tbes_pkg::ST_DIVWAIT && div_done) begin
      ax_mag <= quot_x;
      ay_mag <= quot_y;
    end
    if (state == tbes_pkg::ST_SCHI) begin
      acc_lo <= mul_p;
    end
    if (state == tbes_pkg::ST_SCACC) begin
      sel <= sel + 2'd1;
    end
    if (state == tbes_pkg::ST_OUT && res_free) begin
      res.pos_x           <= position_x;
      res.pos_y           <= position_y;
      res.vel_x           <= velocity_x;
      res.vel_y           <= velocity_y;
      res.propellant_left <= propellant;
      res.thrust_applied  <= applied;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tbes_checker.sv -----
// ----------------------------------------------------------------------------
// tbes_checker
// Port-level checks on the thrusted body Euler step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thrusted_body_euler_step_assert.svh"

module tbes_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_ready,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire tbes_pkg::res_t res
);

  `TBES_ASSERT_NEXT_ANY(a_reset_state, clk, rst, !res_valid && cmd_ready)
  `TBES_ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready)
  `TBES_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))
  `TBES_ASSERT_NEXT(a_idle_res_drop, clk, rst, res_valid && res_ready && cmd_ready, !res_valid)

endmodule

bind thrusted_body_euler_step tbes_checker u_tbes_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire

// ----- bench/tb_thrusted_body_euler_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thrusted_body_euler_step
// Sends tick commands and register writes to the Euler step block. A local
// model of the body predicts each result, and every result is checked field
// by field. Directed ticks cover zero force, small burns, fuel exhaustion and
// saturation. Random flights follow under changing mass and thrust settings.
// ----------------------------------------------------------------------------

module tb_thrusted_body_euler_step;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     PRINT_LIMIT    = 100;
  localparam longint POS_MAX        = 64'sd549755813887;
  localparam longint POS_MIN        = -64'sd549755813888;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_ready;
  tbes_pkg::cmd_t cmd       = '0;
  logic           res_valid;
  logic           res_ready = 1'b0;
  tbes_pkg::res_t res;
  logic           psel      = 1'b0;
  logic           penable   = 1'b0;
  logic           pwrite    = 1'b0;
  logic [3:0]     paddr     = '0;
  logic [31:0]    pwdata    = '0;
  logic [31:0]    prdata;
  logic           pready;

  bit             steady      = 1'b0;
  int             errors      = 0;
  int             idle_cycles = 0;
  tbes_pkg::res_t expected_states[$];

  longint dry_mass   = 38400;
  longint start_fuel = 12800;
  longint thrust     = 500;
  longint burn_rate  = 26;
  longint px = 0, py = 0, vx = 0, vy = 0;
  longint fuel = 12800;

  thrusted_body_euler_step u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic longint clamp40(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint times_dt(input longint v, input longint dt);
    return (v * dt) / 65536;
  endfunction

  function automatic tbes_pkg::res_t advance_body(input tbes_pkg::cmd_t c);
    longint         dt, ax, ay, mass, burned;
    bit             on;
    tbes_pkg::res_t r;
    dt = longint'(c.time_step);
    on = c.firing && fuel > 0;
    ax = 0;
    ay = 0;
    if (on) begin
      mass   = dry_mass + fuel;
      ax     = longint'($signed(c.dir_x)) * thrust * 1024 / mass;
      ay     = longint'($signed(c.dir_y)) * thrust * 1024 / mass;
      burned = (burn_rate * dt) >>> 16;
      fuel   = (fuel > burned) ? fuel - burned : 0;
    end
    vx = clamp40(vx + times_dt(ax, dt));
    vy = clamp40(vy + times_dt(ay, dt));
    px = clamp40(px + times_dt(vx, dt));
    py = clamp40(py + times_dt(vy, dt));
    r.pos_x           = px[39:0];
    r.pos_y           = py[39:0];
    r.vel_x           = vx[39:0];
    r.vel_y           = vy[39:0];
    r.propellant_left = fuel[23:0];
    r.thrust_applied  = on;
    return r;
  endfunction

  task automatic send_tick(input int dt, input bit fire, input int dx, input int dy);
    tbes_pkg::cmd_t c;
    c.time_step = dt[15:0];
    c.firing    = fire;
    c.dir_x     = dx[15:0];
    c.dir_y     = dy[15:0];
    @(negedge clk);
    while (!steady && $urandom_range(99) < 19) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    expected_states.push_back(advance_body(c));
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input tbes_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tbes_pkg::REG_DRY_MASS:   dry_mass  = longint'(val[23:0]);
      tbes_pkg::REG_START_PROP: begin
        start_fuel = longint'(val[23:0]);
        fuel       = start_fuel;
      end
      tbes_pkg::REG_MAX_THRUST: thrust    = longint'(val[15:0]);
      tbes_pkg::REG_BURN_RATE:  burn_rate = longint'(val[23:0]);
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_regs();
    tbes_pkg::reg_idx_t idx;
    logic [31:0]        want;
    for (int i = 0; i < 4; i++) begin
      idx = tbes_pkg::reg_idx_t'(i);
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      case (idx)
        tbes_pkg::REG_DRY_MASS:   want = 32'(dry_mass);
        tbes_pkg::REG_START_PROP: want = 32'(start_fuel);
        tbes_pkg::REG_MAX_THRUST: want = 32'(thrust);
        default:                  want = 32'(burn_rate);
      endcase
      if (prdata !== want) begin
        flag_error($sformatf("%s read %0d want %0d", idx.name(), prdata, want));
      end
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_reg(input int unsigned typical_max);
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(typical_max);
    endcase
  endfunction

  task automatic test_reset_state();
    check_regs();
    send_tick(0, 1'b0, 0, 0);
    send_tick(65535, 1'b1, 16384, 0);
    send_tick(32768, 1'b1, -16384, 16384);
    send_tick(1, 1'b1, -32768, 32767);
    send_tick(0, 1'b1, 0, 0);
    send_tick(65535, 1'b0, 12345, -777);
    send_tick(65535, 1'b1, 0, -16384);
  endtask

  task automatic test_zero_force_and_small_burn();
    settle();
    write_reg(tbes_pkg::REG_MAX_THRUST, 32'd0);
    write_reg(tbes_pkg::REG_BURN_RATE, 32'd256);
    write_reg(tbes_pkg::REG_DRY_MASS, 32'hFFFF_FFFF);
    write_reg(tbes_pkg::REG_START_PROP, 32'h00FF_FFFF);
    check_regs();
    send_tick(65535, 1'b1, 16384, -16384);
    settle();
    write_reg(tbes_pkg::REG_BURN_RATE, 32'd1);
    send_tick(100, 1'b1, -16384, 16384);
    settle();
    write_reg(tbes_pkg::REG_MAX_THRUST, 32'd1000);
    send_tick(65535, 1'b1, 16384, 16384);
  endtask

  task automatic test_fuel_exhaust();
    settle();
    write_reg(tbes_pkg::REG_DRY_MASS, 32'd38400);
    write_reg(tbes_pkg::REG_START_PROP, 32'd5);
    write_reg(tbes_pkg::REG_BURN_RATE, 32'hFFFF_FFFF);
    write_reg(tbes_pkg::REG_MAX_THRUST, 32'd500);
    check_regs();
    send_tick(65535, 1'b1, 16384, 0);
    send_tick(65535, 1'b1, 16384, 0);
    send_tick(65535, 1'b0, 0, 16384);
  endtask

  task automatic test_saturation();
    settle();
    write_reg(tbes_pkg::REG_DRY_MASS, 32'd0);
    write_reg(tbes_pkg::REG_BURN_RATE, 32'd0);
    write_reg(tbes_pkg::REG_START_PROP, 32'd1);
    write_reg(tbes_pkg::REG_MAX_THRUST, 32'h0000_FFFF);
    check_regs();
    repeat (3) send_tick(65535, 1'b1, 32767, -32768);
    repeat (4) send_tick(65535, 1'b1, -32768, 32767);
    repeat (2) send_tick(65535, 1'b0, 0, 0);
  endtask

  task automatic test_random_flight();
    int dt, dx, dy;
    bit fire;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      steady = (phase == 2);
      write_reg(tbes_pkg::REG_DRY_MASS, pick_reg(1 << 20));
      write_reg(tbes_pkg::REG_MAX_THRUST, pick_reg(5000));
      write_reg(tbes_pkg::REG_BURN_RATE, pick_reg(4096));
      write_reg(tbes_pkg::REG_START_PROP, pick_reg(1 << 20));
      check_regs();
      repeat (250) begin
        case ($urandom_range(9))
          0:       dt = 0;
          1:       dt = 65535;
          default: dt = $urandom_range(65535);
        endcase
        fire = $urandom_range(9) < 7;
        dx = ($urandom_range(4) == 0) ? int'($urandom) : int'($urandom_range(32768)) - 16384;
        dy = ($urandom_range(4) == 0) ? int'($urandom) : int'($urandom_range(32768)) - 16384;
        send_tick(dt, fire, dx, dy);
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    res_ready <= steady || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin : check_results
    tbes_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_states.size() == 0) begin
        flag_error("result with no command pending");
      end else begin
        want = expected_states.pop_front();
        if (res.pos_x !== want.pos_x)
          flag_error($sformatf("pos_x got %0d want %0d", res.pos_x, want.pos_x));
        if (res.pos_y !== want.pos_y)
          flag_error($sformatf("pos_y got %0d want %0d", res.pos_y, want.pos_y));
        if (res.vel_x !== want.vel_x)
          flag_error($sformatf("vel_x got %0d want %0d", res.vel_x, want.vel_x));
        if (res.vel_y !== want.vel_y)
          flag_error($sformatf("vel_y got %0d want %0d", res.vel_y, want.vel_y));
        if (res.propellant_left !== want.propellant_left)
          flag_error($sformatf("propellant_left got %0d want %0d",
                               res.propellant_left, want.propellant_left));
        if (res.thrust_applied !== want.thrust_applied)
          flag_error($sformatf("thrust_applied got %0b want %0b",
                               res.thrust_applied, want.thrust_applied));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_zero_force_and_small_burn();
    test_fuel_exhaust();
    test_saturation();
    test_random_flight();
    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
